@@ rtl/hcbd_pkg.sv @@
package hcbd_pkg;

	// Characters that frame a size line.
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;

	// Bytes skipped after the data of a chunk.
	localparam logic [1:0] TRAILER_LEN = 2'd2;

	// Queue between the classifier and the decoder.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Decoder phase. Every phase up to PH_IGNORE lies inside a size line.
	typedef enum logic [3:0] {
		PH_LINE_START = 4'd0,
		PH_WS         = 4'd1,
		PH_SIGN       = 4'd2,
		PH_ZERO       = 4'd3,
		PH_DIGITS     = 4'd4,
		PH_IGNORE     = 4'd5,
		PH_DATA       = 4'd6,
		PH_SKIP       = 4'd7,
		PH_END        = 4'd8
	} phase_t;

	// End-of-body status.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_IN_LINE = 2'd1,
		ST_IN_DATA = 2'd2
	} status_t;

	// A classified body byte as it travels through the queue.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       hex_ok;
		logic [3:0] hex_val;
		logic       is_space;
		logic       is_plus;
		logic       is_minus;
		logic       is_x;
		logic       is_cr;
		logic       is_lf;
	} q_entry_t;

endpackage

@@ rtl/hcbd_in_if.sv @@
interface hcbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/hcbd_out_if.sv @@
interface hcbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       done_res;
	logic [1:0] status;

	modport source (output valid, output out_byte, output out_valid, output done_res,
		output status, input ready);
	modport sink (input valid, input out_byte, input out_valid, input done_res,
		input status, output ready);
endinterface

@@ rtl/hcbd_front.sv @@
module hcbd_front
	import hcbd_pkg::*;
(
	hcbd_in_if.sink          body,
	input  logic [QCNT_W-1:0] q_count,
	output logic             q_push,
	output q_entry_t         q_wdata
);

	// Sort one byte into the character classes the size-line parser needs.
	function automatic q_entry_t classify(input logic [7:0] c, input logic last);
		q_entry_t e;
		e.data     = c;
		e.last     = last;
		e.hex_ok   = 1'b1;
		e.hex_val  = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			e.hex_val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			e.hex_val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			e.hex_val = 4'(c - 8'h37);
		end else begin
			e.hex_ok = 1'b0;
		end
		e.is_space = (c == CH_SPACE) || (c >= CH_HT && c <= CH_CR);
		e.is_plus  = (c == CH_PLUS);
		e.is_minus = (c == CH_MINUS);
		e.is_x     = (c == CH_X_LO) || (c == CH_X_UP);
		e.is_cr    = (c == CH_CR);
		e.is_lf    = (c == CH_LF);
		return e;
	endfunction

	// Accept a transaction whenever the queue has room.
	assign body.ready = (q_count != QCNT_W'(QUEUE_DEPTH));
	assign q_push     = body.valid && body.ready;
	assign q_wdata    = classify(body.in_byte, body.in_last);

endmodule

@@ rtl/hcbd_queue.sv @@
module hcbd_queue
	import hcbd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  q_entry_t          wdata,
	input  logic              pop,
	output logic              rvalid,
	output q_entry_t          rdata,
	output logic [QCNT_W-1:0] count
);

	q_entry_t          slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign do_pop = pop && (count_q != '0);
	assign rvalid = (count_q != '0);
	assign rdata  = slots_q[rd_ptr_q];
	assign count  = count_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/hcbd_back.sv @@
module hcbd_back
	import hcbd_pkg::*;
#(
	parameter int SIZE_BITS = 32
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  q_entry_t   q_entry,
	output logic       q_pop,
	hcbd_out_if.source result
);

	phase_t               phase_q, phase_u, p_cr;
	logic [SIZE_BITS-1:0] acc_q, acc_u, acc_next;
	logic                 neg_q, neg_u;
	logic                 cr_q, cr_u;
	logic [1:0]           skip_q, skip_u;
	logic                 take;
	logic                 emit;
	status_t              st;

	logic                 res_valid_q;
	logic [7:0]           res_byte_q;
	logic                 res_emit_q;
	logic                 res_done_q;
	status_t              res_status_q;

	// Pull a transaction when the output register is free or being drained.
	assign take  = q_valid && (!res_valid_q || result.ready);
	assign q_pop = take;

	// Saturating acc * 16 + digit: overflow exactly when the top nibble is set.
	assign acc_next = (|acc_q[SIZE_BITS-1 -: 4]) ? '1 : {acc_q[SIZE_BITS-5:0], q_entry.hex_val};

	// A held CR that turns out not to end the line is a parser character too.
	always_comb begin
		case (phase_q)
			PH_LINE_START, PH_WS: p_cr = PH_WS;
			default:              p_cr = PH_IGNORE;
		endcase
	end

	// Next state for one byte, before the end-of-body restart.
	always_comb begin
		phase_u = phase_q;
		acc_u   = acc_q;
		neg_u   = neg_q;
		cr_u    = cr_q;
		skip_u  = skip_q;
		if (phase_q <= PH_IGNORE) begin
			if (cr_q && q_entry.is_lf) begin
				cr_u    = 1'b0;
				phase_u = (neg_q || acc_q == '0) ? PH_END : PH_DATA;
			end else begin
				phase_u = cr_q ? p_cr : phase_q;
				cr_u    = q_entry.is_cr;
				if (!q_entry.is_cr) begin
					case (phase_u)
						PH_LINE_START, PH_WS: begin
							if (q_entry.is_space) begin
								phase_u = PH_WS;
							end else if (q_entry.is_plus || q_entry.is_minus) begin
								neg_u   = q_entry.is_minus;
								phase_u = PH_SIGN;
							end else if (q_entry.hex_ok && q_entry.hex_val == 4'd0) begin
								phase_u = PH_ZERO;
							end else if (q_entry.hex_ok) begin
								acc_u   = acc_next;
								phase_u = PH_DIGITS;
							end else begin
								phase_u = PH_IGNORE;
							end
						end
						PH_SIGN: begin
							if (q_entry.hex_ok && q_entry.hex_val == 4'd0) begin
								phase_u = PH_ZERO;
							end else if (q_entry.hex_ok) begin
								acc_u   = acc_next;
								phase_u = PH_DIGITS;
							end else begin
								phase_u = PH_IGNORE;
							end
						end
						PH_ZERO: begin
							if (q_entry.is_x) begin
								phase_u = PH_DIGITS;
							end else if (q_entry.hex_ok) begin
								acc_u   = acc_next;
								phase_u = PH_DIGITS;
							end else begin
								phase_u = PH_IGNORE;
							end
						end
						PH_DIGITS: begin
							if (q_entry.hex_ok) begin
								acc_u   = acc_next;
								phase_u = PH_DIGITS;
							end else begin
								phase_u = PH_IGNORE;
							end
						end
						default: begin
							phase_u = PH_IGNORE;
						end
					endcase
				end
			end
		end else if (phase_q == PH_DATA) begin
			// The count is nonzero whenever data is entered.
			acc_u = acc_q - SIZE_BITS'(1);
			if (acc_u == '0) begin
				phase_u = PH_SKIP;
				skip_u  = TRAILER_LEN;
			end
		end else if (phase_q == PH_SKIP) begin
			if (skip_q != 2'd0) begin
				skip_u = skip_q - 2'd1;
			end
			if (skip_u == 2'd0) begin
				phase_u = PH_LINE_START;
				acc_u   = '0;
				neg_u   = 1'b0;
				cr_u    = 1'b0;
			end
		end else begin
			phase_u = PH_END;
		end
	end

	// Result of the byte: payload flag and end-of-body status.
	always_comb begin
		emit = (phase_q == PH_DATA);
		st   = ST_OK;
		if (q_entry.last) begin
			if (phase_u <= PH_IGNORE) begin
				st = (phase_u != PH_LINE_START || cr_u) ? ST_IN_LINE : ST_OK;
			end else if (phase_u == PH_DATA) begin
				st = ST_IN_DATA;
			end else begin
				st = ST_OK;
			end
		end
	end

	// Decoder state; the byte marked last restarts at a fresh size line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINE_START;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			cr_q    <= 1'b0;
			skip_q  <= 2'd0;
		end else if (take) begin
			if (q_entry.last) begin
				phase_q <= PH_LINE_START;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				cr_q    <= 1'b0;
				skip_q  <= 2'd0;
			end else begin
				phase_q <= phase_u;
				acc_q   <= acc_u;
				neg_q   <= neg_u;
				cr_q    <= cr_u;
				skip_q  <= skip_u;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= emit || q_entry.last;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (take) begin
			res_byte_q   <= emit ? q_entry.data : 8'd0;
			res_emit_q   <= emit;
			res_done_q   <= q_entry.last;
			res_status_q <= st;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.out_byte  = res_byte_q;
	assign result.out_valid = res_emit_q;
	assign result.done_res  = res_done_q;
	assign result.status    = res_status_q;

endmodule

@@ rtl/http_chunked_body_decoder_core.sv @@
// A byte accepted on the input is written into the queue, then decoded into the output
// register. Throughput: one byte per cycle unless the output stalls; the decoder
// state loop updates once per byte.
// A four-entry queue lets the input side accept up to four bytes while the output stalls.
// Reset (arst_n low, asynchronous): queue empty, no result pending, decoder at
// the start of a size line with a zero count.
module http_chunked_body_decoder_core
	import hcbd_pkg::*;
#(
	parameter int SIZE_BITS = 32
)
(
	input  logic       clk,
	input  logic       arst_n,
	hcbd_in_if.sink    body,
	hcbd_out_if.source result
);

	logic              q_push;
	logic              q_pop;
	logic              q_valid;
	q_entry_t          q_wdata;
	q_entry_t          q_rdata;
	logic [QCNT_W-1:0] q_count;

	// Byte classification and input handshake.
	hcbd_front u_front (
		.body    (body),
		.q_count (q_count),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	// Queue between classifier and decoder.
	hcbd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rvalid (q_valid),
		.rdata  (q_rdata),
		.count  (q_count)
	);

	// Chunk decoder and output register.
	hcbd_back #(
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_rdata),
		.q_pop   (q_pop),
		.result  (result)
	);

	// A push without a pop grows the queue by exactly one entry.
	a_queue_grow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && !(q_pop && q_valid) |=> q_count == $past(q_count) + QCNT_W'(1))
		else $error("queue level did not grow on push");

	// Every result carries either a payload byte or the end of the body.
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.out_valid || result.done_res))
		else $error("result with neither payload nor end of body");

	// A status other than ok is reported only on the end of the body.
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.done_res |-> result.status == ST_OK)
		else $error("status reported before end of body");

endmodule

@@ tb/hcbd_decode_check.sv @@
`timescale 1ns / 100ps

module hcbd_decode_check
	import hcbd_pkg::*;
#(
	parameter int SIZE_BITS = 32
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       body_valid,
	input  logic       body_ready,
	input  logic [7:0] body_byte,
	input  logic       body_last,
	input  logic       res_valid,
	input  logic       res_ready,
	input  logic [7:0] res_byte,
	input  logic       res_payload,
	input  logic       res_done,
	input  logic [1:0] res_status,
	output int         errors,
	output int         pending
);

	// One decoded result as the block should present it.
	typedef struct packed {
		logic [7:0] data;
		logic       payload;
		logic       done;
		status_t    status;
	} decoded_t;

	localparam logic [SIZE_BITS-1:0] COUNT_MAX = '1;
	localparam logic [SIZE_BITS-1:0] RADIX     = 16;
	localparam logic [4:0]           NOT_HEX   = 5'd16;

	decoded_t             decoded_q[$];
	phase_t               phase;
	logic [SIZE_BITS-1:0] chunk_count;
	logic                 minus_sign;
	logic                 held_cr;
	logic [1:0]           skip_left;

	// Value of a hex digit, or NOT_HEX for any other byte.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 5'(c - "0");
		if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
		if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
		return NOT_HEX;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_HT && c <= CH_CR);
	endfunction

	task automatic new_line();
		phase       = PH_LINE_START;
		chunk_count = '0;
		minus_sign  = 1'b0;
		held_cr     = 1'b0;
		skip_left   = '0;
	endtask

	// Shift one digit into the chunk size, saturating at the top of the range.
	task automatic add_digit(input logic [4:0] d);
		if (chunk_count > (COUNT_MAX - SIZE_BITS'(d)) / RADIX)
			chunk_count = COUNT_MAX;
		else
			chunk_count = chunk_count * RADIX + SIZE_BITS'(d);
	endtask

	// A leading zero may still open a hex prefix.
	task automatic first_digit(input logic [4:0] d);
		if (d == 5'd0) begin
			phase = PH_ZERO;
		end else if (d != NOT_HEX) begin
			add_digit(d);
			phase = PH_DIGITS;
		end else begin
			phase = PH_IGNORE;
		end
	endtask

	task automatic next_digit(input logic [4:0] d);
		if (d != NOT_HEX) begin
			add_digit(d);
			phase = PH_DIGITS;
		end else begin
			phase = PH_IGNORE;
		end
	endtask

	// One character of a size line goes through the number parser.
	task automatic parse_size_char(input logic [7:0] c);
		logic [4:0] d;
		d = hex_value(c);
		case (phase)
			PH_LINE_START, PH_WS: begin
				if (is_blank(c)) begin
					phase = PH_WS;
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					minus_sign = (c == CH_MINUS);
					phase = PH_SIGN;
				end else begin
					first_digit(d);
				end
			end
			PH_SIGN: begin
				first_digit(d);
			end
			PH_ZERO: begin
				if (c == CH_X_LO || c == CH_X_UP)
					phase = PH_DIGITS;
				else
					next_digit(d);
			end
			PH_DIGITS: begin
				next_digit(d);
			end
			default: begin
			end
		endcase
	endtask

	// Advance the decoder by one body byte and queue the result it causes.
	task automatic decode_byte(input logic [7:0] c, input logic last);
		decoded_t r;
		logic     payload;
		payload = 1'b0;
		if (phase <= PH_IGNORE) begin
			if (held_cr && c == CH_LF) begin
				held_cr = 1'b0;
				phase = (minus_sign || chunk_count == '0) ? PH_END : PH_DATA;
			end else begin
				// A CR held back without a following LF is an ordinary line character.
				if (held_cr) begin
					held_cr = 1'b0;
					parse_size_char(CH_CR);
				end
				if (c == CH_CR)
					held_cr = 1'b1;
				else
					parse_size_char(c);
			end
		end else if (phase == PH_DATA) begin
			payload = 1'b1;
			if (chunk_count != '0)
				chunk_count--;
			if (chunk_count == '0) begin
				phase = PH_SKIP;
				skip_left = TRAILER_LEN;
			end
		end else if (phase == PH_SKIP) begin
			if (skip_left != '0)
				skip_left--;
			if (skip_left == '0)
				new_line();
		end else begin
			phase = PH_END;
		end

		if (payload || last) begin
			r.data    = payload ? c : 8'h00;
			r.payload = payload;
			r.done    = last;
			r.status  = ST_OK;
			if (last) begin
				if (phase <= PH_IGNORE)
					r.status = (phase != PH_LINE_START || held_cr) ? ST_IN_LINE : ST_OK;
				else if (phase == PH_DATA)
					r.status = ST_IN_DATA;
				new_line();
			end
			decoded_q.push_back(r);
		end
	endtask

	// Predict on every accepted byte and compare every accepted result.
	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			new_line();
			decoded_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (body_valid && body_ready)
				decode_byte(body_byte, body_last);
			if (res_valid && res_ready) begin
				if (decoded_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result byte=%02h payload=%0b done=%0b status=%0d",
						$time, res_byte, res_payload, res_done, res_status);
				end else begin
					want = decoded_q.pop_front();
					if (res_byte !== want.data || res_payload !== want.payload ||
						res_done !== want.done || res_status !== want.status) begin
						errors++;
						$display("%0t: mismatch expected byte=%02h payload=%0b done=%0b status=%0d, actual byte=%02h payload=%0b done=%0b status=%0d",
							$time, want.data, want.payload, want.done, want.status,
							res_byte, res_payload, res_done, res_status);
					end
				end
			end
			pending = decoded_q.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench
	import hcbd_pkg::*;
();

	localparam int BODY_TARGET = 700;
	localparam int IDLE_PCT    = 23;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       steady;
	int         errors;
	int         pending;
	int         sent;
	logic [7:0] body_bytes[$];

	hcbd_in_if  body_if ();
	hcbd_out_if result_if ();

	http_chunked_body_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body_if),
		.result (result_if)
	);

	hcbd_decode_check decode_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.body_valid  (body_if.valid),
		.body_ready  (body_if.ready),
		.body_byte   (body_if.in_byte),
		.body_last   (body_if.in_last),
		.res_valid   (result_if.valid),
		.res_ready   (result_if.ready),
		.res_byte    (result_if.out_byte),
		.res_payload (result_if.out_valid),
		.res_done    (result_if.done_res),
		.res_status  (result_if.status),
		.errors      (errors),
		.pending     (pending)
	);

	always #5 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// The result side stalls at random except during the steady stretch.
	initial begin
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_if.ready <= arst_n && (steady || $urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
		if (d < 4'd10)
			return 8'("0") + 8'(d);
		return (upper ? 8'("A") : 8'("a")) + 8'(d) - 8'd10;
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			body_bytes.push_back(s[i]);
	endtask

	task automatic push_line(input string s);
		push_text(s);
		body_bytes.push_back(CH_CR);
		body_bytes.push_back(CH_LF);
	endtask

	// Size line with random blanks, sign, prefix, digit case and extension.
	task automatic put_size_line(input int unsigned size, input bit huge, input bit minus);
		logic [3:0]  digs[$];
		int unsigned v;
		if ($urandom_range(99) < 25) begin
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(5))
					0: body_bytes.push_back(CH_SPACE);
					1: body_bytes.push_back(CH_HT);
					2: body_bytes.push_back(CH_LF);
					3: body_bytes.push_back(8'h0B);
					4: body_bytes.push_back(8'h0C);
					default: begin
						body_bytes.push_back(CH_CR);
						body_bytes.push_back(CH_SPACE);
					end
				endcase
			end
		end
		if (minus)
			body_bytes.push_back(CH_MINUS);
		else if ($urandom_range(99) < 15)
			body_bytes.push_back(CH_PLUS);
		if ($urandom_range(99) < 20) begin
			body_bytes.push_back("0");
			body_bytes.push_back($urandom_range(1) ? CH_X_UP : CH_X_LO);
		end
		if (huge) begin
			// Eight or more significant digits: the top of the range or saturation.
			body_bytes.push_back(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(1))));
			repeat ($urandom_range(7, 10))
				body_bytes.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
		end else begin
			if ($urandom_range(99) < 15)
				body_bytes.push_back("0");
			v = size;
			do begin
				digs.push_front(v[3:0]);
				v = v >> 4;
			end while (v != 0);
			foreach (digs[i])
				body_bytes.push_back(hex_char(digs[i], 1'($urandom_range(1))));
		end
		if ($urandom_range(99) < 20) begin
			body_bytes.push_back(";");
			repeat ($urandom_range(0, 5))
				body_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
		end
		body_bytes.push_back(CH_CR);
		body_bytes.push_back(CH_LF);
	endtask

	// One transaction on the body channel, with random idle cycles ahead of it.
	task automatic send_byte(input logic [7:0] c, input logic last);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			body_if.valid <= 1'b0;
			@(posedge clk);
		end
		body_if.valid   <= 1'b1;
		body_if.in_byte <= c;
		body_if.in_last <= last;
		do @(posedge clk); while (!body_if.ready);
		sent++;
	endtask

	// The last byte of the queued body carries the end mark.
	task automatic send_body();
		foreach (body_bytes[i])
			send_byte(body_bytes[i], i == body_bytes.size() - 1);
		body_bytes.delete();
	endtask

	initial begin
		int          kind;
		int          cut;
		int unsigned size;
		bit          huge;
		bit          minus_term;

		arst_n          <= 1'b0;
		steady          <= 1'b0;
		body_if.valid   <= 1'b0;
		body_if.in_byte <= 8'h00;
		body_if.in_last <= 1'b0;
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ends on the final payload byte, with both extreme data values.
		push_line("2");
		body_bytes.push_back(8'h00);
		body_bytes.push_back(8'hFF);
		send_body();
		// A sign with no digits terminates the body.
		push_line("-");
		send_body();
		// A bare LF is whitespace, and a prefix with no digits is size zero.
		push_text(" ");
		body_bytes.push_back(CH_LF);
		push_line("0X");
		send_body();
		// A CR without LF stops the number; the body then ends owing data.
		push_text("1");
		body_bytes.push_back(CH_CR);
		push_line("z");
		send_body();
		// Ending on a held CR is inside the size line.
		body_bytes.push_back(CH_CR);
		send_body();
		// Explicit sign and an extension; ends right after the trailer skip.
		push_line("+1;e");
		push_text("Q");
		body_bytes.push_back(CH_CR);
		body_bytes.push_back(CH_LF);
		send_body();

		// Random bodies: mostly well formed, some noise, some truncated.
		while (sent < BODY_TARGET) begin
			steady <= (sent >= 250 && sent < 400);
			kind = $urandom_range(99);
			if (kind < 12) begin
				repeat ($urandom_range(1, 12))
					body_bytes.push_back(8'($urandom_range(255)));
			end else begin
				huge = (kind < 18);
				repeat ($urandom_range(0, 3)) begin
					size = ($urandom_range(9) == 0) ? $urandom_range(16, 200) : $urandom_range(1, 8);
					put_size_line(size, 1'b0, 1'b0);
					repeat (size)
						body_bytes.push_back(8'($urandom_range(255)));
					if ($urandom_range(4) != 0) begin
						body_bytes.push_back(CH_CR);
						body_bytes.push_back(CH_LF);
					end else begin
						repeat (2)
							body_bytes.push_back(8'($urandom_range(255)));
					end
				end
				if (huge) begin
					// Such a chunk can never finish, so the body ends inside it.
					put_size_line(0, 1'b1, 1'b0);
					repeat ($urandom_range(1, 6))
						body_bytes.push_back(8'($urandom_range(255)));
				end else begin
					minus_term = ($urandom_range(9) == 0);
					put_size_line(minus_term ? $urandom_range(1, 8) : 0, 1'b0, minus_term);
					body_bytes.push_back(CH_CR);
					body_bytes.push_back(CH_LF);
					if ($urandom_range(4) == 0) begin
						repeat ($urandom_range(1, 4))
							body_bytes.push_back(8'($urandom_range(255)));
					end
					if ($urandom_range(99) < 20) begin
						cut = $urandom_range(1, body_bytes.size());
						while (body_bytes.size() > cut)
							body_bytes.delete(body_bytes.size() - 1);
					end
				end
			end
			send_body();
		end
		body_if.valid <= 1'b0;
		steady <= 1'b0;

		// Drain, then keep watching for anything unexpected before the verdict.
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ http_chunked_body_decoder_core.f @@
rtl/hcbd_pkg.sv
rtl/hcbd_in_if.sv
rtl/hcbd_out_if.sv
rtl/hcbd_front.sv
rtl/hcbd_queue.sv
rtl/hcbd_back.sv
rtl/http_chunked_body_decoder_core.sv
tb/hcbd_decode_check.sv
tb/testbench.sv
